[rtl/core/csc_pkg.sv]
// Shared types and constants for the calibration sample coverage unit.
// Used by csc_cell and calibration_sample_coverage_unit; depends on nothing.
package csc_pkg;

    localparam int VAL_W      = 16;
    localparam int DIST_W     = 18;
    localparam int ENOUGH_W   = 7;
    localparam int OUT_CNT_W  = 7;
    localparam int NUM_VALS   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 112;

    localparam logic MODE_OFFER = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DIST_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENOUGH_COUNT   = 1'd1;

    localparam logic [DIST_W-1:0]   DIST_THRESHOLD_RST = 18'd6554;
    localparam logic [ENOUGH_W-1:0] ENOUGH_COUNT_RST   = 7'd40;
    localparam logic [DIST_W-1:0]   BEST_INIT          = '1;

    typedef logic [NUM_VALS-1:0][VAL_W-1:0] csc_view_t;

    // One probe word travelling down the cell row.
    typedef struct packed {
        logic              valid;
        csc_view_t         vals;
        logic [DIST_W-1:0] best;
    } csc_probe_t;

endpackage

[rtl/core/csc_cell.sv]
// One storage cell of the sample row: holds a stored view and folds its
// L1 distance into the passing probe. Depends on csc_pkg.
module csc_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CNT_W-1:0]    count,
    input  logic                wr_en,
    input  csc_pkg::csc_view_t  wr_view,
    input  csc_pkg::csc_probe_t probe_in,
    output csc_pkg::csc_probe_t probe_out
);
    import csc_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

    csc_view_t            sample_reg;
    csc_probe_t           probe_reg;
    csc_probe_t           probe_next;
    logic [NUM_VALS-1:0][VAL_W-1:0] diff;
    logic [DIST_W-1:0]    l1_dist;
    logic                 active;

    assign active = MY_IDX < count;

    always_comb begin
        for (int k = 0; k < NUM_VALS; k++) begin
            if (probe_in.vals[k] > sample_reg[k]) begin
                diff[k] = probe_in.vals[k] - sample_reg[k];
            end else begin
                diff[k] = sample_reg[k] - probe_in.vals[k];
            end
        end
        l1_dist = {2'b00, diff[0]} + {2'b00, diff[1]} + {2'b00, diff[2]} + {2'b00, diff[3]};
    end

    always_comb begin
        probe_next = probe_in;
        if (probe_in.valid && active && (l1_dist < probe_in.best)) begin
            probe_next.best = l1_dist;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (count == MY_IDX)) begin
            sample_reg <= wr_view;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg.valid <= 1'b0;
        end else begin
            probe_reg.valid <= probe_next.valid;
        end
        probe_reg.vals <= probe_next.vals;
        probe_reg.best <= probe_next.best;
    end

    assign probe_out = probe_reg;

endmodule

[rtl/core/calibration_sample_coverage_unit.sv]
// Top level of the calibration sample coverage unit: control, trackers and
// the row of csc_cell storage cells. Depends on csc_pkg and csc_cell.
//
// Usage: each word on the s_ channel is either a calibration view to offer
// (s_tuser = 0) or a request to clear the sample store (s_tuser = 1). Every
// word produces exactly one result word on the m_ channel: whether the view
// was stored, the sample count, the coverage trackers and good_enough.
// Write the two registers through the cfg_ port only while idle (not enforced).
//
// Scan: a view that has to be compared against stored samples travels as a
// probe through all STORE_DEPTH cells, one cell per cycle; its result is
// written to the output register after the scan, and a new word is taken
// only once the block is back in idle. A clear word, a view offered to an
// empty store and a view offered to a full store skip the cell row.
// The block works on one word at a time; s_tready is high only while idle.
//
// Reset: aresetn clears the count, the trackers, the control state and
// restores both registers to their defaults. Stored views need no clearing
// because only cells below the count are ever consulted.
// Stall: the result sits in an output register. The block takes no new
// words while it waits; a finished result that finds the output register
// still full waits until m_tready frees it.
module calibration_sample_coverage_unit #(
    parameter int STORE_DEPTH = 64,
    parameter int FRAC_BITS   = 15
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input words.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, lowest bit up: pos_x[15:0], pos_y[31:16], view_size[47:32],
    // view_skew[63:48].
    input  logic [csc_pkg::S_DATA_W-1:0]      s_tdata,
    // s_tuser: mode (0 offer a view, 1 clear the store).
    input  logic                              s_tuser,
    // Result words.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, lowest bit up: accepted[0], good_enough[1], sample_count[8:2],
    // min_x[24:9], max_x[40:25], min_y[56:41], max_y[72:57],
    // max_size[88:73], max_skew[104:89], zero fill[111:105].
    output logic [csc_pkg::M_DATA_W-1:0]      m_tdata,
    // Configuration writes.
    input  logic                              cfg_we,
    input  logic [csc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [csc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import csc_pkg::*;

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);
    localparam logic [32:0] ONE_FIX = 33'd1 << FRAC_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // Configuration registers.
    logic [DIST_W-1:0]   dist_threshold_reg;
    logic [ENOUGH_W-1:0] enough_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_threshold_reg <= DIST_THRESHOLD_RST;
            enough_count_reg   <= ENOUGH_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DIST_THRESHOLD: dist_threshold_reg <= cfg_wdata[DIST_W-1:0];
                REG_ENOUGH_COUNT:   enough_count_reg   <= cfg_wdata[ENOUGH_W-1:0];
                default: ;
            endcase
        end
    end

    // Control and tracker state.
    logic [1:0]       state_reg, state_next;
    logic             launch_reg, launch_next;
    logic             clear_reg;
    csc_view_t        query_reg;
    logic [DIST_W-1:0] best_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [VAL_W-1:0] lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg, hi_size_reg, hi_skew_reg;
    logic [VAL_W-1:0] lo_x_next, hi_x_next, lo_y_next, hi_y_next;
    logic [VAL_W-1:0] hi_size_next, hi_skew_next;
    logic             m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic             s_fire;
    logic             out_free;
    logic             finish_fire;
    logic             accept_w;
    logic             skip_scan;
    csc_view_t        sat_view;
    csc_probe_t       probe [STORE_DEPTH+1];
    logic             spans_ok;
    logic             enough_w;
    logic [CNT_W+ENOUGH_W-1:0] count_wide;

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign finish_fire = (state_reg == ST_FINISH) && out_free;
    assign skip_scan   = (s_tuser == MODE_CLEAR) || (count_reg == '0) ||
                         (count_reg == DEPTH_CNT);

    // Values above 1.0 are saturated to 1.0 before use.
    always_comb begin
        for (int k = 0; k < NUM_VALS; k++) begin
            if ({17'd0, s_tdata[k*VAL_W +: VAL_W]} > ONE_FIX) begin
                sat_view[k] = ONE_FIX[VAL_W-1:0];
            end else begin
                sat_view[k] = s_tdata[k*VAL_W +: VAL_W];
            end
        end
    end

    // The cell row. The probe enters cell 0 in the same cycle as launch_reg.
    assign probe[0].valid = launch_reg;
    assign probe[0].vals  = query_reg;
    assign probe[0].best  = BEST_INIT;

    for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
        csc_cell #(
            .CELL_IDX (i),
            .CNT_W    (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .count     (count_reg),
            .wr_en     (finish_fire && accept_w),
            .wr_view   (query_reg),
            .probe_in  (probe[i]),
            .probe_out (probe[i+1])
        );
    end

    // Decision: an empty store always accepts, a full store never does.
    always_comb begin
        if (clear_reg) begin
            accept_w = 1'b0;
        end else if (count_reg == '0) begin
            accept_w = 1'b1;
        end else if (count_reg == DEPTH_CNT) begin
            accept_w = 1'b0;
        end else begin
            accept_w = best_reg > dist_threshold_reg;
        end
    end

    // Tracker update for the finishing word.
    always_comb begin
        count_next   = count_reg;
        lo_x_next    = lo_x_reg;
        hi_x_next    = hi_x_reg;
        lo_y_next    = lo_y_reg;
        hi_y_next    = hi_y_reg;
        hi_size_next = hi_size_reg;
        hi_skew_next = hi_skew_reg;
        if (clear_reg) begin
            count_next   = '0;
            lo_x_next    = '0;
            hi_x_next    = '0;
            lo_y_next    = '0;
            hi_y_next    = '0;
            hi_size_next = '0;
            hi_skew_next = '0;
        end else if (accept_w) begin
            count_next = count_reg + 1'b1;
            if (count_reg == '0) begin
                lo_x_next    = query_reg[0];
                hi_x_next    = query_reg[0];
                lo_y_next    = query_reg[1];
                hi_y_next    = query_reg[1];
                hi_size_next = query_reg[2];
                hi_skew_next = query_reg[3];
            end else begin
                if (query_reg[0] < lo_x_reg)    lo_x_next    = query_reg[0];
                if (query_reg[0] > hi_x_reg)    hi_x_next    = query_reg[0];
                if (query_reg[1] < lo_y_reg)    lo_y_next    = query_reg[1];
                if (query_reg[1] > hi_y_reg)    hi_y_next    = query_reg[1];
                if (query_reg[2] > hi_size_reg) hi_size_next = query_reg[2];
                if (query_reg[3] > hi_skew_reg) hi_skew_next = query_reg[3];
            end
        end
    end

    // Coverage is good enough on count or when every span reaches 1.0.
    // For size and skew the highest value stands as the span. The trackers keep highest >= lowest, so no span wraps.
    assign spans_ok = ({17'd0, VAL_W'(hi_x_next - lo_x_next)} >= ONE_FIX) &&
                      ({17'd0, VAL_W'(hi_y_next - lo_y_next)} >= ONE_FIX) &&
                      ({17'd0, hi_size_next} >= ONE_FIX) &&
                      ({17'd0, hi_skew_next} >= ONE_FIX);
    assign count_wide = {{ENOUGH_W{1'b0}}, count_next};
    assign enough_w   = (count_wide >= {{CNT_W{1'b0}}, enough_count_reg}) || spans_ok;

    assign m_tdata_next = {7'd0, hi_skew_next, hi_size_next, hi_y_next, lo_y_next,
                           hi_x_next, lo_x_next, count_wide[OUT_CNT_W-1:0],
                           enough_w, accept_w};

    // Sequencer.
    always_comb begin
        state_next  = state_reg;
        launch_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (skip_scan) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next  = ST_SCAN;
                        launch_next = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (probe[STORE_DEPTH].valid) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            launch_reg   <= 1'b0;
            count_reg    <= '0;
            lo_x_reg     <= '0;
            hi_x_reg     <= '0;
            lo_y_reg     <= '0;
            hi_y_reg     <= '0;
            hi_size_reg  <= '0;
            hi_skew_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            if (finish_fire) begin
                count_reg   <= count_next;
                lo_x_reg    <= lo_x_next;
                hi_x_reg    <= hi_x_next;
                lo_y_reg    <= lo_y_next;
                hi_y_reg    <= hi_y_next;
                hi_size_reg <= hi_size_next;
                hi_skew_reg <= hi_skew_next;
            end
            if (finish_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            clear_reg <= (s_tuser == MODE_CLEAR);
            query_reg <= sat_view;
        end
        if ((state_reg == ST_SCAN) && probe[STORE_DEPTH].valid) begin
            best_reg <= probe[STORE_DEPTH].best;
        end
        if (finish_fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // The probe only ever leaves the cell row during a scan.
    a_probe_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        probe[STORE_DEPTH].valid |-> (state_reg == ST_SCAN))
        else $error("probe left the cell row outside a scan");

    // The store never holds more views than it has cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("sample count exceeds the store depth");

    // A stored view raises the count by exactly one.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish_fire && accept_w) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted view did not advance the count");

    // A launch only happens on entry to a scan.
    a_launch_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        launch_reg |-> (state_reg == ST_SCAN))
        else $error("probe launched outside a scan");
`endif

endmodule
